[rtl/pll_pkg.sv]
// Package for the positional list unit: field widths, request kinds,
// status codes and the command word broadcast to the cell row.
// No dependencies.
`timescale 1ns / 1ps

package pll_pkg;

    localparam int DATA_W = 32;
    localparam int IDX_W  = 8;
    localparam int KIND_W = 3;
    localparam int ST_W   = 2;

    localparam logic [KIND_W-1:0] KIND_READ   = 3'd0;
    localparam logic [KIND_W-1:0] KIND_HEAD   = 3'd1;
    localparam logic [KIND_W-1:0] KIND_TAIL   = 3'd2;
    localparam logic [KIND_W-1:0] KIND_INSERT = 3'd3;
    localparam logic [KIND_W-1:0] KIND_DELETE = 3'd4;

    localparam logic [ST_W-1:0] ST_DONE    = 2'd0;
    localparam logic [ST_W-1:0] ST_INVALID = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL    = 2'd2;

    localparam logic [1:0] OP_HOLD   = 2'd0;
    localparam logic [1:0] OP_INSERT = 2'd1;
    localparam logic [1:0] OP_DELETE = 2'd2;

    typedef struct packed {
        logic [1:0]        op;
        logic [IDX_W-1:0]  pos;
        logic [DATA_W-1:0] data;
    } cell_cmd_t;

endpackage

[rtl/pll_if.sv]
// Valid/ready channel interfaces for request and response words.
// Depends on pll_pkg.
`timescale 1ns / 1ps

interface pll_req_if
    import pll_pkg::*;
;
    logic                     valid;
    logic                     ready;
    logic [KIND_W-1:0]        kind;
    logic [IDX_W-1:0]         index;
    logic signed [DATA_W-1:0] value;

    modport source (output valid, output kind, output index, output value, input ready);
    modport sink   (input valid, input kind, input index, input value, output ready);
endinterface

interface pll_rsp_if
    import pll_pkg::*;
#(
    parameter int LEN_W = 7
);
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] read_value;
    logic [ST_W-1:0]          status;
    logic [LEN_W-1:0]         length;

    modport source (output valid, output read_value, output status, output length,
                    input ready);
    modport sink   (input valid, input read_value, input status, input length,
                     output ready);
endinterface

[rtl/pll_cell.sv]
// One list cell: holds one entry and shifts from its neighbors on insert/delete.
// Depends on pll_pkg.
`timescale 1ns / 1ps

module pll_cell
    import pll_pkg::*;
(
    input  logic              clk,
    input  cell_cmd_t         cmd,
    input  logic [IDX_W-1:0]  pos_id,
    input  logic [DATA_W-1:0] left_data,
    input  logic [DATA_W-1:0] right_data,
    output logic [DATA_W-1:0] data,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] data_reg;
    logic [DATA_W-1:0] data_next;

    always_comb
    begin
        data_next = data_reg;
        case (cmd.op)
            OP_INSERT:
            begin
                if (pos_id > cmd.pos)
                begin
                    data_next = left_data;
                end
                else if (pos_id == cmd.pos)
                begin
                    data_next = cmd.data;
                end
            end
            OP_DELETE:
            begin
                if (pos_id >= cmd.pos)
                begin
                    data_next = right_data;
                end
            end
            default:
            begin
                data_next = data_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data    = data_reg;
    assign rd_data = (pos_id == cmd.pos) ? data_reg : '0;

endmodule

[rtl/positional_list_insert_delete_unit.sv]
// Top level of the positional list unit: request decode, cell row, response register.
// Depends on pll_pkg, pll_req_if, pll_rsp_if and pll_cell.
//
// Usage:
//   req channel carries one request word: kind, index, value. kind selects
//   read at index, insert at head, insert at tail, insert before index or
//   delete at index. rsp channel returns one word per request: read_value,
//   status (done, invalid, full) and the list length after the request.
//   Latency: the response word is valid on the cycle after the request is
//   accepted. Throughput: one request per cycle while the response word is
//   taken or none waits; every cell of the row shifts from its neighbor in
//   the same cycle, so the cell array update sets the rate.
//   Stall: the response register holds its word while rsp.ready is low and
//   req.ready stays low until it is taken; a waiting word is replaced in the
//   same cycle it is taken, so no bubble is added.
//   Reset: length returns to zero at once; no clearing pass is needed since
//   cells beyond the length are never read.
//   CAPACITY sets the number of cells (2 to 256) and the width of length.
`timescale 1ns / 1ps

module positional_list_insert_delete_unit
    import pll_pkg::*;
#(
    parameter int CAPACITY = 64
)
(
    input  logic       clk,
    input  logic       rst_n,
    pll_req_if.sink    req,
    pll_rsp_if.source  rsp
);

    localparam int LEN_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = LEN_W + IDX_W;
    localparam logic [LEN_W-1:0] CAP_LEN = LEN_W'(CAPACITY);

    logic                  accept;
    logic [LEN_W-1:0]      count_reg;
    logic [LEN_W-1:0]      count_next;
    logic                  rsp_valid_reg;
    logic [DATA_W-1:0]     rd_value_reg;
    logic [DATA_W-1:0]     rd_value_next;
    logic [ST_W-1:0]       status_reg;
    logic [ST_W-1:0]       status_next;
    logic [LEN_W-1:0]      length_reg;
    cell_cmd_t             cmd;
    logic [1:0]            op;
    logic [IDX_W-1:0]      pos;
    logic                  full;
    logic                  idx_lt;
    logic                  idx_le;
    logic [DATA_W-1:0]     cell_data [CAPACITY];
    logic [DATA_W-1:0]     cell_rd   [CAPACITY];
    logic [DATA_W-1:0]     rd_or;

    assign req.ready = !rsp_valid_reg || rsp.ready;
    assign accept    = req.valid && req.ready;

    assign full   = (count_reg == CAP_LEN);
    assign idx_lt = (CMP_W'(req.index) <  CMP_W'(count_reg));
    assign idx_le = (CMP_W'(req.index) <= CMP_W'(count_reg));

    always_comb
    begin
        rd_or = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            rd_or = rd_or | cell_rd[i];
        end
    end

    always_comb
    begin
        op            = OP_HOLD;
        pos           = req.index;
        rd_value_next = '0;
        status_next   = ST_DONE;
        case (req.kind)
            KIND_READ:
            begin
                if (idx_lt)
                begin
                    rd_value_next = rd_or;
                end
                else
                begin
                    rd_value_next = '1;
                    status_next   = ST_INVALID;
                end
            end
            KIND_HEAD:
            begin
                pos = '0;
                if (full)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    op = OP_INSERT;
                end
            end
            KIND_TAIL:
            begin
                pos = IDX_W'(count_reg);
                if (full)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    op = OP_INSERT;
                end
            end
            KIND_INSERT:
            begin
                if (!idx_le)
                begin
                    status_next = ST_INVALID;
                end
                else if (full)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    op = OP_INSERT;
                end
            end
            KIND_DELETE:
            begin
                if (!idx_lt)
                begin
                    status_next = ST_INVALID;
                end
                else
                begin
                    op = OP_DELETE;
                end
            end
            default:
            begin
                status_next = ST_INVALID;
            end
        endcase
    end

    always_comb
    begin
        cmd.op   = accept ? op : OP_HOLD;
        cmd.pos  = pos;
        cmd.data = req.value;
    end

    always_comb
    begin
        count_next = count_reg;
        case (cmd.op)
            OP_INSERT: count_next = count_reg + LEN_W'(1);
            OP_DELETE: count_next = count_reg - LEN_W'(1);
            default:   count_next = count_reg;
        endcase
    end

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++)
        begin : g_cell
            logic [DATA_W-1:0] left_data;
            logic [DATA_W-1:0] right_data;

            if (g == 0)
            begin : g_first
                assign left_data = '0;
            end
            else
            begin : g_left
                assign left_data = cell_data[g-1];
            end

            if (g == CAPACITY - 1)
            begin : g_last
                assign right_data = '0;
            end
            else
            begin : g_right
                assign right_data = cell_data[g+1];
            end

            pll_cell u_cell (
                .clk        (clk),
                .cmd        (cmd),
                .pos_id     (IDX_W'(g)),
                .left_data  (left_data),
                .right_data (right_data),
                .data       (cell_data[g]),
                .rd_data    (cell_rd[g])
            );
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (accept)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rd_value_reg <= rd_value_next;
            status_reg   <= status_next;
            length_reg   <= count_next;
        end
    end

    assign rsp.valid      = rsp_valid_reg;
    assign rsp.read_value = rd_value_reg;
    assign rsp.status     = status_reg;
    assign rsp.length     = length_reg;

    // checks
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CAP_LEN)
        else $error("list length above capacity");

    a_count_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !accept |=> $stable(count_reg))
        else $error("length changed without a request");

    a_full_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && full && req.kind != KIND_DELETE) |=> (count_reg == CAP_LEN))
        else $error("full store changed by a non-delete request");

    a_rsp_follows: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> rsp.valid)
        else $error("response word missing after request");

    a_full_len: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && status_reg == ST_FULL) |-> (length_reg == CAP_LEN))
        else $error("full status with length below capacity");

endmodule

[verif/tb.sv]
// Testbench for positional_list_insert_delete_unit: a directed table, then random traffic.
// Responses are checked field by field against the table's typed words or a local list predictor.
// Depends on pll_pkg, pll_req_if, pll_rsp_if and the unit's RTL.
`timescale 1ns / 1ps

module tb
    import pll_pkg::*;
;

    localparam int CAPACITY        = 64;
    localparam int LEN_W           = 7;
    localparam int HOLD_OFF_CYCLES = 60;
    localparam int DRAIN_CYCLES    = 8;
    localparam int CYCLE_LIMIT     = 200000;
    localparam int N_DIRECTED      = 24;

    localparam logic [KIND_W-1:0] KIND_RSVD5 = 3'd5;
    localparam logic [KIND_W-1:0] KIND_RSVD6 = 3'd6;
    localparam logic [KIND_W-1:0] KIND_RSVD7 = 3'd7;

    typedef struct packed {
        logic signed [DATA_W-1:0] read_value;
        logic [ST_W-1:0]          status;
        logic [LEN_W-1:0]         length;
    } list_result_t;

    typedef struct packed {
        logic [KIND_W-1:0]        kind;
        logic [IDX_W-1:0]         index;
        logic signed [DATA_W-1:0] value;
        logic                     typed;
        logic signed [DATA_W-1:0] want_rd;
        logic [ST_W-1:0]          want_st;
        logic [LEN_W-1:0]         want_len;
    } list_row_t;

    logic clk;
    logic rst_n;

    pll_req_if                  req_ch ();
    pll_rsp_if #(.LEN_W(LEN_W)) rsp_ch ();

    positional_list_insert_delete_unit #(
        .CAPACITY (CAPACITY)
    ) i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    logic signed [DATA_W-1:0] list_cells [CAPACITY];
    int                       list_len = 0;
    list_result_t             pending_results [$];
    int                       mismatches = 0;
    int                       send_idle_pct;
    int                       recv_idle_pct;
    bit                       hold_off_req = 1'b0;
    bit                       growing = 1'b1;
    int                       cycle_count = 0;

    // typed rows carry their expected word; others use the predictor
    list_row_t directed_rows [N_DIRECTED] = '{
        '{KIND_READ,   8'd0,   32'sd0,           1'b1, -32'sd1,          ST_INVALID, 7'd0},
        '{KIND_DELETE, 8'd0,   32'sd0,           1'b1, 32'sd0,           ST_INVALID, 7'd0},
        '{KIND_INSERT, 8'd1,   32'sd5,           1'b1, 32'sd0,           ST_INVALID, 7'd0},
        '{KIND_DELETE, 8'd255, 32'sd0,           1'b1, 32'sd0,           ST_INVALID, 7'd0},
        '{KIND_INSERT, 8'd0,   32'sh7FFF_FFFF,   1'b1, 32'sd0,           ST_DONE,    7'd1},
        '{KIND_HEAD,   8'd0,   32'sh8000_0000,   1'b1, 32'sd0,           ST_DONE,    7'd2},
        '{KIND_TAIL,   8'd255, -32'sd1,          1'b1, 32'sd0,           ST_DONE,    7'd3},
        '{KIND_READ,   8'd0,   32'sd0,           1'b1, 32'sh8000_0000,   ST_DONE,    7'd3},
        '{KIND_READ,   8'd2,   32'sd0,           1'b1, -32'sd1,          ST_DONE,    7'd3},
        '{KIND_READ,   8'd3,   32'sd0,           1'b1, -32'sd1,          ST_INVALID, 7'd3},
        '{KIND_READ,   8'd255, 32'sd0,           1'b1, -32'sd1,          ST_INVALID, 7'd3},
        '{KIND_INSERT, 8'd3,   32'sh1234_5678,   1'b0, 32'sd0,           ST_DONE,    7'd0},
        '{KIND_INSERT, 8'd5,   32'sd7,           1'b1, 32'sd0,           ST_INVALID, 7'd4},
        '{KIND_INSERT, 8'd1,   32'sh5555_5555,   1'b0, 32'sd0,           ST_DONE,    7'd0},
        '{KIND_HEAD,   8'd128, 32'shAAAA_AAAA,   1'b0, 32'sd0,           ST_DONE,    7'd0},
        '{KIND_RSVD5,  8'd0,   32'sd1,           1'b1, 32'sd0,           ST_INVALID, 7'd6},
        '{KIND_RSVD6,  8'd1,   32'sd0,           1'b1, 32'sd0,           ST_INVALID, 7'd6},
        '{KIND_RSVD7,  8'd255, -32'sd1,          1'b1, 32'sd0,           ST_INVALID, 7'd6},
        '{KIND_READ,   8'd1,   32'sd0,           1'b0, 32'sd0,           ST_DONE,    7'd0},
        '{KIND_DELETE, 8'd5,   32'sd0,           1'b0, 32'sd0,           ST_DONE,    7'd0},
        '{KIND_DELETE, 8'd0,   32'sd0,           1'b0, 32'sd0,           ST_DONE,    7'd0},
        '{KIND_READ,   8'd0,   32'sd0,           1'b0, 32'sd0,           ST_DONE,    7'd0},
        '{KIND_DELETE, 8'd4,   32'sd0,           1'b1, 32'sd0,           ST_INVALID, 7'd4},
        '{KIND_READ,   8'd3,   32'sd0,           1'b0, 32'sd0,           ST_DONE,    7'd0}
    };

    function automatic list_result_t apply_list_request(
        input logic [KIND_W-1:0]        kind,
        input logic [IDX_W-1:0]         index,
        input logic signed [DATA_W-1:0] value
    );
        list_result_t res;
        int           pos;
        res.read_value = '0;
        res.status     = ST_DONE;
        pos            = -1;
        case (kind)
            KIND_READ:
                if (int'(index) < list_len)
                    res.read_value = list_cells[index];
                else
                begin
                    res.read_value = -32'sd1;
                    res.status     = ST_INVALID;
                end
            KIND_HEAD:
                if (list_len >= CAPACITY) res.status = ST_FULL;
                else pos = 0;
            KIND_TAIL:
                if (list_len >= CAPACITY) res.status = ST_FULL;
                else pos = list_len;
            KIND_INSERT:
                if (int'(index) > list_len) res.status = ST_INVALID;
                else if (list_len >= CAPACITY) res.status = ST_FULL;
                else pos = int'(index);
            KIND_DELETE:
                if (int'(index) >= list_len)
                    res.status = ST_INVALID;
                else
                begin
                    for (int i = int'(index); i + 1 < list_len; i++)
                        list_cells[i] = list_cells[i + 1];
                    list_len--;
                end
            default:
                res.status = ST_INVALID;
        endcase
        if (pos >= 0)
        begin
            for (int i = list_len; i > pos; i--)
                list_cells[i] = list_cells[i - 1];
            list_cells[pos] = value;
            list_len++;
        end
        res.length = LEN_W'(list_len);
        return res;
    endfunction

    // offer one word; on acceptance record what the response must be
    task automatic send_word(
        input logic [KIND_W-1:0]        kind,
        input logic [IDX_W-1:0]         index,
        input logic signed [DATA_W-1:0] value,
        input bit                       typed,
        input list_result_t             typed_want
    );
        list_result_t predicted;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.kind  <= kind;
        req_ch.index <= index;
        req_ch.value <= value;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        predicted = apply_list_request(kind, index, value);
        pending_results.push_back(typed ? typed_want : predicted);
    endtask

    task automatic wait_drained();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // list grows toward full, then shrinks toward empty, then again
    task automatic send_random_words(input int n_words);
        logic [KIND_W-1:0]        kind;
        logic [IDX_W-1:0]         index;
        logic signed [DATA_W-1:0] value;
        int                       roll;
        int                       head_w;
        int                       tail_w;
        int                       ins_w;
        int                       del_w;
        for (int n = 0; n < n_words; n++)
        begin
            if (list_len == CAPACITY && $urandom_range(0, 3) == 0)
                growing = 1'b0;
            else if (list_len == 0 && $urandom_range(0, 3) == 0)
                growing = 1'b1;
            if (growing)
            begin
                head_w = 18; tail_w = 18; ins_w = 30; del_w = 14;
            end
            else
            begin
                head_w = 5; tail_w = 5; ins_w = 10; del_w = 60;
            end
            roll = $urandom_range(0, 99);
            if (roll < head_w)
                kind = KIND_HEAD;
            else if (roll < head_w + tail_w)
                kind = KIND_TAIL;
            else if (roll < head_w + tail_w + ins_w)
                kind = KIND_INSERT;
            else if (roll < head_w + tail_w + ins_w + del_w)
                kind = KIND_DELETE;
            else if (roll < 97)
                kind = KIND_READ;
            else if (roll == 97)
                kind = KIND_RSVD5;
            else if (roll == 98)
                kind = KIND_RSVD6;
            else
                kind = KIND_RSVD7;
            if ($urandom_range(0, 9) < 8)
                index = IDX_W'($urandom_range(0, list_len));
            else
                index = IDX_W'($urandom_range(0, 255));
            case ($urandom_range(0, 9))
                0:       value = 32'sh7FFF_FFFF;
                1:       value = 32'sh8000_0000;
                2:       value = -32'sd1;
                3:       value = 32'sd0;
                default: value = $urandom;
            endcase
            send_word(kind, index, value, 1'b0, '0);
        end
    endtask

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                rsp_ch.ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
            end
            rsp_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin : check_responses
        list_result_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("response word with nothing pending");
                mismatches++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (rsp_ch.read_value !== want.read_value)
                begin
                    $error("read_value: expected %0d, got %0d", want.read_value,
                           rsp_ch.read_value);
                    mismatches++;
                end
                if (rsp_ch.status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, rsp_ch.status);
                    mismatches++;
                end
                if (rsp_ch.length !== want.length)
                begin
                    $error("length: expected %0d, got %0d", want.length, rsp_ch.length);
                    mismatches++;
                end
            end
        end
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Some tests failed");
        $finish;
    end

    initial
    begin
        list_result_t want;
        rst_n         = 1'b0;
        req_ch.valid  = 1'b0;
        req_ch.kind   = KIND_READ;
        req_ch.index  = '0;
        req_ch.value  = '0;
        send_idle_pct = 29;
        recv_idle_pct = 72;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[r])
        begin
            want.read_value = directed_rows[r].want_rd;
            want.status     = directed_rows[r].want_st;
            want.length     = directed_rows[r].want_len;
            send_word(directed_rows[r].kind, directed_rows[r].index,
                      directed_rows[r].value, directed_rows[r].typed, want);
        end

        send_random_words(250);
        wait_drained();

        send_idle_pct = 72;
        recv_idle_pct = 29;
        hold_off_req  = 1'b1;
        send_random_words(250);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_off_req  = 1'b1;
        send_random_words(100);
        wait_drained();
        send_random_words(100);

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
